>>> rtl/core/pipeline_delay_bound_assert.svh
// ----------------------------------------------------------------------------
// Pipeline delay bound assertion macros
// Clocked assertion shorthands shared by the update stage and the top module.
// ----------------------------------------------------------------------------
`ifndef PIPELINE_DELAY_BOUND_ASSERT_SVH
`define PIPELINE_DELAY_BOUND_ASSERT_SVH

// Same-cycle property under clk, masked while rst_n is low.
`define PDB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication under clk, masked while rst_n is low.
`define PDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/pdb_pkg.sv
// ----------------------------------------------------------------------------
// Pipeline delay bound package
// Widths, register indexes and shared types of the delay bound core.
// ----------------------------------------------------------------------------
package pdb_pkg;

  localparam int MAX_STAGES = 16;
  localparam int JOB_W      = 8;
  localparam int STAGE_W    = 4;
  localparam int PRIO_W     = 8;
  localparam int TIME_W     = 16;
  localparam int CNT_W      = 5;
  localparam int T1_W       = 24;
  localparam int T23_W      = 20;
  localparam int OUT_W      = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_JOB   = 2'd0,
    CFG_TARGET_PRIO  = 2'd1,
    CFG_STAGE_COUNT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [JOB_W-1:0]   job;
    logic [STAGE_W-1:0] stage;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  exec_time;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [JOB_W-1:0]  target_job;
    logic [PRIO_W-1:0] target_prio;
    logic [CNT_W-1:0]  stage_count;
  } cfg_t;

endpackage

>>> rtl/core/pdb_in_stage.sv
// ----------------------------------------------------------------------------
// Pipeline delay bound input stage
// Registers one input item and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
module pdb_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pdb_pkg::item_t item_i,
  input  logic           take,
  output logic           hold_valid,
  output pdb_pkg::item_t hold_item
);
  import pdb_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_stall   = valid_r && !take;
  assign accept     = in_valid && !in_stall;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_i;
    end
  end

endmodule

>>> rtl/core/pdb_update.sv
// ----------------------------------------------------------------------------
// Pipeline delay bound update stage
// Folds one item into the running maxima and terms and forms the bound.
// ----------------------------------------------------------------------------
`include "pipeline_delay_bound_assert.svh"

module pdb_update (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  pdb_pkg::item_t             item,
  input  pdb_pkg::cfg_t              cfg,
  output logic                       result_load,
  output logic [pdb_pkg::OUT_W-1:0]  result
);
  import pdb_pkg::*;

  logic [TIME_W-1:0] job_max_time_r;
  logic [TIME_W-1:0] job_max_time_nxt;
  logic [T1_W-1:0]   job_max_sum_r;
  logic [T1_W-1:0]   job_max_sum_nxt;
  logic [T23_W-1:0]  high_sum_r;
  logic [T23_W-1:0]  high_sum_nxt;
  logic [T23_W-1:0]  low_sum_r;
  logic [T23_W-1:0]  low_sum_nxt;
  logic [TIME_W-1:0] high_max_r [MAX_STAGES];
  logic [TIME_W-1:0] low_max_r  [MAX_STAGES];

  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  stage_ext;
  logic              in_use;
  logic              not_last_stage;
  logic              is_target;
  logic              high;
  logic              low;
  logic [TIME_W-1:0] jmt_base;
  logic [TIME_W-1:0] hs_cur;
  logic [TIME_W-1:0] ls_cur;
  logic [T1_W:0]     sum1_ext;
  logic [T1_W-1:0]   sum1_sat;
  logic              high_we;
  logic              low_we;
  logic              clear;

  assign n_eff          = (cfg.stage_count > CNT_W'(MAX_STAGES)) ? CNT_W'(MAX_STAGES)
                                                                 : cfg.stage_count;
  assign stage_ext      = {1'b0, item.stage};
  assign in_use         = stage_ext < n_eff;
  assign not_last_stage = (stage_ext + CNT_W'(1)) < n_eff;
  assign is_target      = item.job == cfg.target_job;
  assign high           = is_target || (item.prio < cfg.target_prio);
  assign low            = !is_target && (item.prio > cfg.target_prio);
  assign jmt_base       = (item.stage == '0) ? '0 : job_max_time_r;
  assign hs_cur         = high_max_r[item.stage];
  assign ls_cur         = low_max_r[item.stage];
  assign sum1_ext       = {1'b0, job_max_sum_r}
                        + (T1_W+1)'(item.exec_time - jmt_base);
  assign sum1_sat       = sum1_ext[T1_W] ? '1 : sum1_ext[T1_W-1:0];
  assign clear          = fire && item.last;

  always_comb begin
    job_max_time_nxt = job_max_time_r;
    job_max_sum_nxt  = job_max_sum_r;
    high_sum_nxt     = high_sum_r;
    low_sum_nxt      = low_sum_r;
    high_we          = 1'b0;
    low_we           = 1'b0;
    if (fire && in_use) begin
      job_max_time_nxt = jmt_base;
      if (high) begin
        if (item.exec_time > jmt_base) begin
          job_max_sum_nxt  = sum1_sat;
          job_max_time_nxt = item.exec_time;
        end
        if (item.exec_time > hs_cur) begin
          high_we = 1'b1;
          if (not_last_stage) begin
            high_sum_nxt = high_sum_r + T23_W'(item.exec_time - hs_cur);
          end
        end
      end else if (low) begin
        if (item.exec_time > ls_cur) begin
          low_we      = 1'b1;
          low_sum_nxt = low_sum_r + T23_W'(item.exec_time - ls_cur);
        end
      end
    end
  end

  assign result_load = clear;
  assign result      = OUT_W'(job_max_sum_nxt) + OUT_W'(high_sum_nxt) + OUT_W'(low_sum_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      job_max_time_r <= '0;
      job_max_sum_r  <= '0;
      high_sum_r     <= '0;
      low_sum_r      <= '0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        high_max_r[i] <= '0;
        low_max_r[i]  <= '0;
      end
    end else begin
      job_max_time_r <= job_max_time_nxt;
      job_max_sum_r  <= job_max_sum_nxt;
      high_sum_r     <= high_sum_nxt;
      low_sum_r      <= low_sum_nxt;
      if (high_we) begin
        high_max_r[item.stage] <= item.exec_time;
      end
      if (low_we) begin
        low_max_r[item.stage] <= item.exec_time;
      end
    end
  end

  `PDB_ASSERT_NEXT(a_clear_after_last, fire && item.last, (job_max_sum_r == '0) && (high_sum_r == '0) && (low_sum_r == '0), "terms not cleared after last item")
  `PDB_ASSERT_NEXT(a_hold_without_item, !fire, $stable(job_max_sum_r) && $stable(high_sum_r) && $stable(low_sum_r), "terms changed without an item")
  `PDB_ASSERT_NEXT(a_job_max_tracks, fire && !item.last && in_use && high && (item.exec_time > jmt_base), job_max_time_r == $past(item.exec_time), "job maximum not taken from item")

endmodule

>>> rtl/core/pdb_out_stage.sv
// ----------------------------------------------------------------------------
// Pipeline delay bound output stage
// Holds one finished bound until the receiver takes it.
// ----------------------------------------------------------------------------
module pdb_out_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [pdb_pkg::OUT_W-1:0] data,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [pdb_pkg::OUT_W-1:0] out_delay_bound,
  output logic                      out_free
);
  import pdb_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [OUT_W-1:0] data_r;

  assign out_free        = !valid_r || !out_stall;
  assign out_valid       = valid_r;
  assign out_delay_bound = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

endmodule

>>> rtl/core/pipeline_delay_bound.sv
// ----------------------------------------------------------------------------
// Pipeline delay bound
// Builds the end-to-end delay bound of one target job from a stream of
// per-stage execution times and emits it on the last item of a data set.
// ----------------------------------------------------------------------------
// Path: the last item is registered in the input stage, folded into the terms
// by the update stage and its bound registered in the output stage (out_valid).
// Throughput: one item per cycle through the per-stage maxima and running
// terms; a last item waits while a bound is held stalled.
// Reset: synchronous, active low; clears all maxima and terms, target job and
// priority to 0 and stage count to 16. Maxima and terms clear again after each bound.
`include "pipeline_delay_bound_assert.svh"

module pipeline_delay_bound (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pdb_pkg::JOB_W-1:0]      in_job_index,
  input  logic [pdb_pkg::STAGE_W-1:0]    in_stage_index,
  input  logic [pdb_pkg::PRIO_W-1:0]     in_job_priority,
  input  logic [pdb_pkg::TIME_W-1:0]     in_exec_time,
  input  logic                           in_last_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pdb_pkg::OUT_W-1:0]      out_delay_bound,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pdb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pdb_pkg::*;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  item_t            in_item;
  item_t            hold_item;
  logic             hold_valid;
  logic             fire;
  logic             out_free;
  logic             result_load;
  logic [OUT_W-1:0] result;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET_JOB:  cfg_nxt.target_job  = JOB_W'(cfg_wdata);
        CFG_TARGET_PRIO: cfg_nxt.target_prio = PRIO_W'(cfg_wdata);
        CFG_STAGE_COUNT: cfg_nxt.stage_count = cfg_wdata[CNT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_job  <= '0;
      cfg_r.target_prio <= '0;
      cfg_r.stage_count <= CNT_W'(MAX_STAGES);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_item = {in_job_index, in_stage_index, in_job_priority, in_exec_time, in_last_item};

  assign fire = hold_valid && (!hold_item.last || out_free);

  pdb_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item_i     (in_item),
    .take       (fire),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  pdb_update u_update (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (hold_item),
    .cfg         (cfg_r),
    .result_load (result_load),
    .result      (result)
  );

  pdb_out_stage u_out_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (result_load),
    .data            (result),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_delay_bound (out_delay_bound),
    .out_free        (out_free)
  );

  `PDB_ASSERT(a_stall_only_when_held, !in_stall || hold_valid, "input stalled with empty input register")
  `PDB_ASSERT(a_result_has_slot, !(fire && hold_item.last) || out_free, "bound produced into a full output register")

endmodule
